// ===== rtl/core/scd_pkg.sv =====
// ----------------------------------------------------------------------------
// scd_pkg
// Shared constants and fixed-point helpers for the spring chain derivative core.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int DEF_MAX_NODES = 64;

	localparam logic [31:0] RST_STIFFNESS = 32'd3276800;
	localparam logic [31:0] RST_REST_LEN  = 32'd6554;
	localparam logic [31:0] RST_DRAG      = 32'd3277;
	localparam logic [31:0] RST_GRAVITY   = 32'd642253;
	localparam logic [31:0] RST_INV_MASS  = 32'd65536;

	typedef enum logic [2:0] {
		REG_STIFFNESS = 3'd0,
		REG_REST_LEN  = 3'd1,
		REG_DRAG      = 3'd2,
		REG_GRAVITY   = 3'd3,
		REG_INV_MASS  = 3'd4
	} reg_idx_t;

	// Q16.16 product scaled back, truncated toward zero
	function automatic logic signed [51:0] trunc16(input logic signed [67:0] p);
		logic signed [67:0] t;
		begin
			if (p < 0) begin
				t = (p + 68'sd65535) >>> 16;
			end else begin
				t = p >>> 16;
			end
			return t[51:0];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
		begin
			if (v > 53'sd2147483647) begin
				return 32'sh7fffffff;
			end else if (v < -53'sd2147483648) begin
				return 32'sh80000000;
			end else begin
				return v[31:0];
			end
		end
	endfunction

endpackage

// ===== rtl/core/spring_chain_derivative_core.sv =====
// A result with parent and child springs runs the spring steps for both springs, one with
// a single spring runs them for that spring, and an anchor result skips them; each spring takes
// a 32-step square root, then a 48-step divide per axis, which a spring of zero length skips.
// Throughput: one input transaction at a time; the next is taken once its results
// have all been delivered. The shared multiplier and the bit-serial root/divide set this.
// Reset: asynchronous, clears the sequencer, chain state and registers to defaults.
// ----------------------------------------------------------------------------
// spring_chain_derivative_core
// Mass-spring chain node derivative, one shared multiply / root / divide datapath.
// ----------------------------------------------------------------------------
module spring_chain_derivative_core #(
	parameter int MAX_NODES = scd_pkg::DEF_MAX_NODES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic               first_node,
	input  logic               last_node,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [5:0]         node_index,
	output logic signed [31:0] dpos_x,
	output logic signed [31:0] dpos_y,
	output logic signed [31:0] dpos_z,
	output logic signed [31:0] accel_x,
	output logic signed [31:0] accel_y,
	output logic signed [31:0] accel_z,
	output logic               chain_done
);
	import scd_pkg::*;

	localparam int CW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_NODES - 1);

	typedef enum logic [4:0] {
		S_IDLE, S_UPD, S_RSTART, S_DIFF, S_SQ_M, S_SQ_A, S_SQRT, S_SQEND,
		S_DIVINIT, S_DIV, S_T_M, S_T_A, S_F_M, S_F_A, S_SPEND,
		S_DRG_M, S_DRG_A, S_ACC_M, S_ACC_A, S_GRAV, S_OUT
	} state_t;

	state_t state_q;

	logic [31:0] k_q, rest_q, drag_q, grav_q, imass_q;

	logic signed [31:0] in_pos_q [3];
	logic signed [31:0] in_vel_q [3];
	logic               in_last_q, anchor_q;
	logic signed [31:0] gp_q [3];
	logic signed [31:0] held_q [3];
	logic signed [31:0] hvel_q [3];
	logic [CW-1:0]      cnt_q;
	logic               open_q, child_q, done_q, ph_q, sp_q;

	logic signed [31:0] d_q [3];
	logic [63:0]        sum_q;
	logic [33:0]        rem_q;
	logic [31:0]        root_q, len_q;
	logic [5:0]         it_q;
	logic [1:0]         ax_q;
	logic signed [31:0] t_q;
	logic signed [33:0] acc_q [3];
	logic signed [67:0] prod_q;

	logic [5:0]         oidx_q;
	logic signed [31:0] odp_q [3];
	logic signed [31:0] res_q [3];
	logic               odone_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [51:0] ptr;
	logic [35:0]        sq_sh, sq_tr;
	logic [33:0]        dv_sh;
	logic signed [33:0] delta;
	logic [15:0]        cnt_ext;
	logic signed [17:0] unit_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign ptr       = trunc16(prod_q);
	assign sq_sh     = {rem_q, sum_q[63:62]};
	assign sq_tr     = {2'b00, root_q, 2'b01};
	assign dv_sh     = {rem_q[32:0], sum_q[47]};
	assign delta     = $signed({2'b00, len_q}) - $signed({2'b00, rest_q});
	assign cnt_ext   = 16'(cnt_q);
	assign unit_c    = (d_q[ax_q] < 0) ? -$signed({1'b0, sum_q[16:0]})
		: $signed({1'b0, sum_q[16:0]});

	always_comb begin
		mul_a = 34'sd0;
		mul_b = 34'sd0;
		case (state_q)
			S_SQ_M: begin
				mul_a = 34'(d_q[ax_q]);
				mul_b = 34'(d_q[ax_q]);
			end
			S_T_M: begin
				mul_a = delta;
				mul_b = 34'(unit_c);
			end
			S_F_M: begin
				mul_a = $signed({2'b00, k_q});
				mul_b = 34'(t_q);
			end
			S_DRG_M: begin
				mul_a = $signed({2'b00, drag_q});
				mul_b = 34'(hvel_q[ax_q]);
			end
			S_ACC_M: begin
				mul_a = $signed({2'b00, imass_q});
				mul_b = 34'(sat32(53'(acc_q[ax_q])));
			end
			default: begin
				mul_a = 34'sd0;
				mul_b = 34'sd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= RST_STIFFNESS;
			rest_q  <= RST_REST_LEN;
			drag_q  <= RST_DRAG;
			grav_q  <= RST_GRAVITY;
			imass_q <= RST_INV_MASS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STIFFNESS: k_q     <= cfg_data;
				REG_REST_LEN:  rest_q  <= cfg_data;
				REG_DRAG:      drag_q  <= cfg_data;
				REG_GRAVITY:   grav_q  <= cfg_data;
				REG_INV_MASS:  imass_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q  <= 1'b0;
			cnt_q   <= '0;
			for (int c = 0; c < 3; c++) begin
				gp_q[c]   <= '0;
				held_q[c] <= '0;
				hvel_q[c] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						in_pos_q[0] <= pos_x;
						in_pos_q[1] <= pos_y;
						in_pos_q[2] <= pos_z;
						in_vel_q[0] <= vel_x;
						in_vel_q[1] <= vel_y;
						in_vel_q[2] <= vel_z;
						in_last_q   <= last_node;
						anchor_q    <= first_node || !open_q;
						ph_q        <= 1'b0;
						if (first_node || !open_q) begin
							child_q <= 1'b0;
							done_q  <= 1'b1;
							state_q <= open_q ? S_RSTART : S_UPD;
						end else begin
							child_q <= 1'b1;
							done_q  <= 1'b0;
							state_q <= S_RSTART;
						end
					end
				end
				S_UPD: begin
					for (int c = 0; c < 3; c++) begin
						gp_q[c]   <= anchor_q ? 32'sd0 : held_q[c];
						held_q[c] <= in_pos_q[c];
						hvel_q[c] <= in_vel_q[c];
					end
					if (anchor_q) begin
						cnt_q <= '0;
					end else if (cnt_q < CNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (in_last_q) begin
						open_q  <= 1'b0;
						child_q <= 1'b0;
						done_q  <= 1'b1;
						ph_q    <= 1'b1;
						state_q <= S_RSTART;
					end else begin
						open_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_RSTART: begin
					oidx_q  <= cnt_ext[5:0];
					odone_q <= done_q;
					sp_q    <= 1'b0;
					for (int c = 0; c < 3; c++) begin
						odp_q[c] <= (cnt_q == '0) ? 32'sd0 : hvel_q[c];
						res_q[c] <= '0;
						acc_q[c] <= '0;
					end
					state_q <= (cnt_q == '0) ? S_OUT : S_DIFF;
				end
				S_DIFF: begin
					for (int c = 0; c < 3; c++) begin
						d_q[c] <= sat32(53'(33'(held_q[c]) -
							33'(sp_q ? in_pos_q[c] : gp_q[c])));
					end
					sum_q   <= '0;
					ax_q    <= 2'd0;
					state_q <= S_SQ_M;
				end
				S_SQ_M: state_q <= S_SQ_A;
				S_SQ_A: begin
					sum_q <= sum_q + prod_q[63:0];
					if (ax_q == 2'd2) begin
						rem_q   <= '0;
						root_q  <= '0;
						it_q    <= '0;
						state_q <= S_SQRT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SQ_M;
					end
				end
				S_SQRT: begin
					if (sq_sh >= sq_tr) begin
						rem_q  <= 34'(sq_sh - sq_tr);
						root_q <= {root_q[30:0], 1'b1};
					end else begin
						rem_q  <= sq_sh[33:0];
						root_q <= {root_q[30:0], 1'b0};
					end
					sum_q <= {sum_q[61:0], 2'b00};
					it_q  <= it_q + 6'd1;
					if (it_q == 6'd31) begin
						state_q <= S_SQEND;
					end
				end
				S_SQEND: begin
					len_q   <= root_q;
					ax_q    <= 2'd0;
					state_q <= (root_q == '0) ? S_SPEND : S_DIVINIT;
				end
				S_DIVINIT: begin
					sum_q   <= {16'd0, (d_q[ax_q] < 0) ? 32'(-d_q[ax_q]) : d_q[ax_q], 16'd0};
					rem_q   <= '0;
					it_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dv_sh >= {2'b00, len_q}) begin
						rem_q <= dv_sh - {2'b00, len_q};
						sum_q <= {sum_q[62:0], 1'b1};
					end else begin
						rem_q <= dv_sh;
						sum_q <= {sum_q[62:0], 1'b0};
					end
					it_q <= it_q + 6'd1;
					if (it_q == 6'd47) begin
						state_q <= S_T_M;
					end
				end
				S_T_M: state_q <= S_T_A;
				S_T_A: begin
					t_q     <= sat32(53'(ptr));
					state_q <= S_F_M;
				end
				S_F_M: state_q <= S_F_A;
				S_F_A: begin
					acc_q[ax_q] <= acc_q[ax_q] + 34'(sat32(-53'(ptr)));
					if (ax_q == 2'd2) begin
						state_q <= S_SPEND;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_DIVINIT;
					end
				end
				S_SPEND: begin
					ax_q <= 2'd0;
					if (!sp_q && child_q) begin
						sp_q    <= 1'b1;
						state_q <= S_DIFF;
					end else begin
						state_q <= S_DRG_M;
					end
				end
				S_DRG_M: state_q <= S_DRG_A;
				S_DRG_A: begin
					acc_q[ax_q] <= acc_q[ax_q] + 34'(sat32(-53'(ptr)));
					if (ax_q == 2'd2) begin
						ax_q    <= 2'd0;
						state_q <= S_ACC_M;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_DRG_M;
					end
				end
				S_ACC_M: state_q <= S_ACC_A;
				S_ACC_A: begin
					res_q[ax_q] <= sat32(53'(ptr));
					if (ax_q == 2'd2) begin
						state_q <= S_GRAV;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_ACC_M;
					end
				end
				S_GRAV: begin
					res_q[1] <= sat32(53'(res_q[1]) - $signed({21'd0, grav_q}));
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= ph_q ? S_IDLE : S_UPD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign node_index = oidx_q;
	assign dpos_x     = odp_q[0];
	assign dpos_y     = odp_q[1];
	assign dpos_z     = odp_q[2];
	assign accel_x    = res_q[0];
	assign accel_y    = res_q[1];
	assign accel_z    = res_q[2];
	assign chain_done = odone_q;

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("input taken while result pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX) else $error("node count beyond range");
	a_anchor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cnt_q == '0) |-> (accel_x == 0 && accel_y == 0 && accel_z == 0))
		else $error("anchor result not zero");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && ph_q) |=> !open_q) else $error("chain left open");
`endif

endmodule
